/* rtl/lbsd_pkg.sv */
package lbsd_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_COUNT = 8;
  localparam int CFG_IDX_W = $clog2(CFG_COUNT);
  localparam int FRAC_BITS_DEFAULT = 8;

  // signed working width for sums, differences and constant products
  localparam int CALC_W = 22;

  // divide by five: floor(x * RECIP / 2^SHIFT) is exact for x below 2^19
  localparam int SUM_W = 19;
  localparam int RECIP_W = 20;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV5_RECIP = 20'd838861;
  localparam int DIV5_SHIFT = 22;

  typedef enum logic [1:0] {
    MODE_CRUISE      = 2'd0,
    MODE_CAUTION     = 2'd1,
    MODE_LANE_CHANGE = 2'd2,
    MODE_EMERGENCY   = 2'd3
  } mode_t;

  localparam logic [1:0] LANE_LEFT    = 2'd0;
  localparam logic [1:0] LANE_CENTER  = 2'd1;
  localparam logic [1:0] LANE_RIGHT   = 2'd2;
  localparam logic [1:0] LANE_UNKNOWN = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRUISE_LIMIT            = 3'd0,
    CFG_STOP_GAP                = 3'd1,
    CFG_EMERGENCY_DISTANCE      = 3'd2,
    CFG_CHANGE_TRIGGER_DISTANCE = 3'd3,
    CFG_LANE_ADVANTAGE          = 3'd4,
    CFG_MIN_CHANGE_GAP          = 3'd5,
    CFG_STOP_ENTER_DISTANCE     = 3'd6,
    CFG_STOP_RELEASE_DISTANCE   = 3'd7
  } cfg_idx_t;

  localparam logic [DATA_W-1:0] RST_CRUISE_LIMIT            = 16'd1024;
  localparam logic [DATA_W-1:0] RST_STOP_GAP                = 16'd384;
  localparam logic [DATA_W-1:0] RST_EMERGENCY_DISTANCE      = 16'd307;
  localparam logic [DATA_W-1:0] RST_CHANGE_TRIGGER_DISTANCE = 16'd3840;
  localparam logic [DATA_W-1:0] RST_LANE_ADVANTAGE          = 16'd1024;
  localparam logic [DATA_W-1:0] RST_MIN_CHANGE_GAP          = 16'd512;
  localparam logic [DATA_W-1:0] RST_STOP_ENTER_DISTANCE     = 16'd768;
  localparam logic [DATA_W-1:0] RST_STOP_RELEASE_DISTANCE   = 16'd896;

  typedef struct packed {
    logic [DATA_W-1:0] cruise_limit;
    logic [DATA_W-1:0] stop_gap;
    logic [DATA_W-1:0] emergency_distance;
    logic [DATA_W-1:0] change_trigger_distance;
    logic [DATA_W-1:0] lane_advantage;
    logic [DATA_W-1:0] min_change_gap;
    logic [DATA_W-1:0] stop_enter_distance;
    logic [DATA_W-1:0] stop_release_distance;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0]        left_distance;
    logic [DATA_W-1:0]        center_distance;
    logic [DATA_W-1:0]        right_distance;
    logic signed [DATA_W-1:0] left_speed;
    logic signed [DATA_W-1:0] center_speed;
    logic signed [DATA_W-1:0] right_speed;
    logic [DATA_W-1:0]        own_speed;
    logic [1:0]               lane_now;
  } sensor_t;

  typedef struct packed {
    mode_t             mode;
    logic [1:0]        lane;
    logic [DATA_W-1:0] raw_speed;
    logic              latch_next;
    logic              emergency;
  } decision_t;

endpackage

/* rtl/lbsd_ifs.sv */
interface lbsd_in_if;
  logic                                valid;
  logic                                ready;
  logic [lbsd_pkg::DATA_W-1:0]         left_distance;
  logic [lbsd_pkg::DATA_W-1:0]         center_distance;
  logic [lbsd_pkg::DATA_W-1:0]         right_distance;
  logic signed [lbsd_pkg::DATA_W-1:0]  left_speed;
  logic signed [lbsd_pkg::DATA_W-1:0]  center_speed;
  logic signed [lbsd_pkg::DATA_W-1:0]  right_speed;
  logic [lbsd_pkg::DATA_W-1:0]         own_speed;
  logic [1:0]                          lane_now;

  modport source (
    output valid, left_distance, center_distance, right_distance,
           left_speed, center_speed, right_speed, own_speed, lane_now,
    input  ready
  );
  modport sink (
    input  valid, left_distance, center_distance, right_distance,
           left_speed, center_speed, right_speed, own_speed, lane_now,
    output ready
  );
endinterface

interface lbsd_out_if;
  logic                        valid;
  logic                        ready;
  lbsd_pkg::mode_t             mode;
  logic [1:0]                  lane_out;
  logic [lbsd_pkg::DATA_W-1:0] speed_out;

  modport source (
    output valid, mode, lane_out, speed_out,
    input  ready
  );
  modport sink (
    input  valid, mode, lane_out, speed_out,
    output ready
  );
endinterface

/* rtl/lbsd_cfg.sv */
module lbsd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lbsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbsd_pkg::DATA_W-1:0]       cfg_data,
  output lbsd_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_limit            <= lbsd_pkg::RST_CRUISE_LIMIT;
      cfg.stop_gap                <= lbsd_pkg::RST_STOP_GAP;
      cfg.emergency_distance      <= lbsd_pkg::RST_EMERGENCY_DISTANCE;
      cfg.change_trigger_distance <= lbsd_pkg::RST_CHANGE_TRIGGER_DISTANCE;
      cfg.lane_advantage          <= lbsd_pkg::RST_LANE_ADVANTAGE;
      cfg.min_change_gap          <= lbsd_pkg::RST_MIN_CHANGE_GAP;
      cfg.stop_enter_distance     <= lbsd_pkg::RST_STOP_ENTER_DISTANCE;
      cfg.stop_release_distance   <= lbsd_pkg::RST_STOP_RELEASE_DISTANCE;
    end else if (cfg_write) begin
      unique case (lbsd_pkg::cfg_idx_t'(cfg_index))
        lbsd_pkg::CFG_CRUISE_LIMIT:            cfg.cruise_limit            <= cfg_data;
        lbsd_pkg::CFG_STOP_GAP:                cfg.stop_gap                <= cfg_data;
        lbsd_pkg::CFG_EMERGENCY_DISTANCE:      cfg.emergency_distance      <= cfg_data;
        lbsd_pkg::CFG_CHANGE_TRIGGER_DISTANCE: cfg.change_trigger_distance <= cfg_data;
        lbsd_pkg::CFG_LANE_ADVANTAGE:          cfg.lane_advantage          <= cfg_data;
        lbsd_pkg::CFG_MIN_CHANGE_GAP:          cfg.min_change_gap          <= cfg_data;
        lbsd_pkg::CFG_STOP_ENTER_DISTANCE:     cfg.stop_enter_distance     <= cfg_data;
        lbsd_pkg::CFG_STOP_RELEASE_DISTANCE:   cfg.stop_release_distance   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lbsd_decide.sv */
module lbsd_decide #(
  parameter int FRAC_BITS = lbsd_pkg::FRAC_BITS_DEFAULT
) (
  input  lbsd_pkg::sensor_t   item,
  input  lbsd_pkg::cfg_t      cfg,
  input  logic                latched,
  output lbsd_pkg::decision_t dec
);

  localparam int W = lbsd_pkg::CALC_W;
  localparam logic signed [W-1:0] ONE  = W'(1 << FRAC_BITS);
  localparam logic signed [W-1:0] HALF = W'(1 << (FRAC_BITS - 1));
  localparam logic signed [W-1:0] TWO  = W'(2 << FRAC_BITS);
  localparam logic signed [W-1:0] ZERO = W'(0);
  localparam logic signed [W-1:0] K4   = W'(4);
  localparam logic signed [W-1:0] K5   = W'(5);
  localparam logic signed [W-1:0] K7   = W'(7);
  localparam logic signed [W-1:0] K10  = W'(10);

  logic signed [W-1:0] lane_dist [3];
  logic signed [W-1:0] spd  [3];

  always_comb begin
    lane_dist[0] = signed'(W'(item.left_distance));
    lane_dist[1] = signed'(W'(item.center_distance));
    lane_dist[2] = signed'(W'(item.right_distance));
    spd[0]  = W'(item.left_speed);
    spd[1]  = W'(item.center_speed);
    spd[2]  = W'(item.right_speed);
  end

  logic [1:0]          curr, best, next;
  logic signed [W-1:0] ego, vmax, front, fspeed, safe, err, cand, hi;
  logic signed [W-1:0] raw, best_dist, gd, gs, slide;
  logic                set_latch, hold, release_cond, gap_ok;
  lbsd_pkg::mode_t     mode;

  always_comb begin
    curr = (item.lane_now == lbsd_pkg::LANE_UNKNOWN) ? lbsd_pkg::LANE_CENTER
                                                     : item.lane_now;
    ego    = signed'(W'(item.own_speed));
    vmax   = signed'(W'(cfg.cruise_limit));
    front  = lane_dist[curr];
    fspeed = spd[curr];
    safe   = signed'(W'(cfg.stop_gap)) + ego;
    raw    = vmax;
    mode   = lbsd_pkg::MODE_CRUISE;
    err    = front - safe;
    cand   = fspeed + (err >>> 1);
    hi     = fspeed - HALF;
    if (hi < ZERO) hi = ZERO;

    // gap-based following
    if (front < (safe <<< 1)) begin
      mode = lbsd_pkg::MODE_CAUTION;
      if (err < ZERO) begin
        raw = (cand > hi) ? hi : cand;
      end else begin
        raw = (cand > vmax) ? vmax : cand;
      end
      if (raw < ZERO) raw = ZERO;
    end

    // traffic-jam standstill latch with release hysteresis
    set_latch = (K5 * ego < ONE)
             && (front < signed'(W'(cfg.stop_enter_distance)))
             && (K5 * fspeed < ONE);
    release_cond = (front > signed'(W'(cfg.stop_release_distance))) || (fspeed > ONE);
    hold = (latched || set_latch) && !release_cond;
    if (hold) begin
      raw  = ZERO;
      mode = lbsd_pkg::MODE_CAUTION;
    end

    // clearer lane search, left to right
    best      = curr;
    best_dist = front;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) != curr)
          && (lane_dist[i] > best_dist + signed'(W'(cfg.lane_advantage)))) begin
        best      = 2'(i);
        best_dist = lane_dist[i];
      end
    end
    // neighbour one step towards the clearer lane, own lane when there is none
    next   = (best > curr) ? curr + 2'd1 : (best < curr) ? curr - 2'd1 : curr;
    gd     = lane_dist[next];
    gs     = spd[next];
    gap_ok = (gd > signed'(W'(cfg.min_change_gap))) && (K10 * gd > K7 * ego);
    slide  = gs - HALF;
    if (slide < ZERO || K5 * gs < ONE) slide = ZERO;

    if ((front < signed'(W'(cfg.change_trigger_distance)))
        && (K5 * fspeed < K4 * vmax) && !hold && (best != curr)) begin
      if (gap_ok) begin
        mode = lbsd_pkg::MODE_LANE_CHANGE;
        raw  = ego + HALF;
        if (raw < TWO) raw = TWO;
        if (raw > vmax) raw = vmax;
      end else if (slide < raw) begin
        raw = slide;
      end
    end

    dec.emergency  = front < signed'(W'(cfg.emergency_distance));
    dec.mode       = dec.emergency ? lbsd_pkg::MODE_EMERGENCY : mode;
    dec.lane       = (mode == lbsd_pkg::MODE_LANE_CHANGE) ? next : curr;
    dec.raw_speed  = raw[lbsd_pkg::DATA_W-1:0];
    dec.latch_next = hold;
  end

endmodule

/* rtl/lane_behavior_speed_decider.sv */
// Lane behaviour and speed decider. Takes one sensor item per clock: nearest
// obstacle distance and speed for the left, centre and right lanes, own speed
// and current lane, and returns one item with behaviour mode, target lane and
// smoothed target speed. Items pass through an input register and a result
// register; an item waits in the first until the second can take its result,
// and a new item is taken every cycle while the consumer keeps up. The decision and
// the 0.2/0.8 smoothing update close their feedback within the single stage
// between the two registers, so back-to-back items see each other's state.
// Configuration registers are written through cfg_write/cfg_index/cfg_data
// and should only change while no item is in flight.
module lane_behavior_speed_decider #(
  parameter int FRAC_BITS = lbsd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  lbsd_in_if.sink                        sensors,
  lbsd_out_if.source                     decision,
  input  logic                           cfg_write,
  input  logic [lbsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbsd_pkg::DATA_W-1:0]    cfg_data
);

  lbsd_pkg::cfg_t      cfg;
  lbsd_pkg::sensor_t   s1_item;
  lbsd_pkg::decision_t dec;
  logic                s1_valid;
  logic                s1_move;
  logic                in_ready;
  logic                out_valid;
  logic [lbsd_pkg::DATA_W-1:0] smoothed_speed;
  logic [lbsd_pkg::DATA_W-1:0] smoothed_speed_next;
  logic                standstill_latched;
  logic [lbsd_pkg::SUM_W-1:0]  smooth_sum;
  logic [lbsd_pkg::PROD_W-1:0] smooth_prod;

  lbsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbsd_decide #(.FRAC_BITS(FRAC_BITS)) u_decide (
    .item    (s1_item),
    .cfg     (cfg),
    .latched (standstill_latched),
    .dec     (dec)
  );

  assign s1_move        = s1_valid && (!out_valid || decision.ready);
  assign in_ready       = !s1_valid || s1_move;
  assign sensors.ready  = in_ready;
  assign decision.valid = out_valid;

  // (raw + 4*smoothed + 2) / 5, rounded to nearest
  assign smooth_sum  = lbsd_pkg::SUM_W'(dec.raw_speed)
                     + {1'b0, smoothed_speed, 2'b00}
                     + lbsd_pkg::SUM_W'(2);
  assign smooth_prod = lbsd_pkg::PROD_W'(smooth_sum)
                     * lbsd_pkg::PROD_W'(lbsd_pkg::DIV5_RECIP);
  assign smoothed_speed_next = dec.emergency ? '0
      : smooth_prod[lbsd_pkg::DIV5_SHIFT +: lbsd_pkg::DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= sensors.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensors.valid && in_ready) begin
      s1_item.left_distance   <= sensors.left_distance;
      s1_item.center_distance <= sensors.center_distance;
      s1_item.right_distance  <= sensors.right_distance;
      s1_item.left_speed      <= sensors.left_speed;
      s1_item.center_speed    <= sensors.center_speed;
      s1_item.right_speed     <= sensors.right_speed;
      s1_item.own_speed       <= sensors.own_speed;
      s1_item.lane_now        <= sensors.lane_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      smoothed_speed     <= '0;
      standstill_latched <= 1'b0;
    end else if (s1_move) begin
      out_valid          <= 1'b1;
      smoothed_speed     <= smoothed_speed_next;
      standstill_latched <= dec.latch_next;
    end else if (decision.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      decision.mode      <= dec.mode;
      decision.lane_out  <= dec.lane;
      decision.speed_out <= smoothed_speed_next;
    end
  end

  a_emergency_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && decision.mode == lbsd_pkg::MODE_EMERGENCY |-> decision.speed_out == '0)
    else $error("emergency result with non-zero speed");

  a_lane_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> decision.lane_out != lbsd_pkg::LANE_UNKNOWN)
    else $error("target lane out of range");

  a_speed_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> decision.speed_out == smoothed_speed)
    else $error("result speed differs from smoothing state");

  a_move_fills: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("decided item lost");

  a_change_unlatched: assert property (@(posedge clk) disable iff (rst)
    out_valid && decision.mode == lbsd_pkg::MODE_LANE_CHANGE |-> !standstill_latched)
    else $error("lane change while standstill latched");

endmodule
